FILE: rtl/gbn_pkg.sv
// Package for the greedy box suppression block: item structs, result kinds,
// register indexes and the control bundle passed along the cell chain.
// No dependencies.
package gbn_pkg;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic        last_box;
    } in_item_t;

    typedef struct packed {
        logic [15:0] box_index;
        logic [1:0]  result_kind;
        logic [5:0]  kept_count;
        logic        last_result;
    } out_item_t;

    typedef struct packed {
        logic valid;
        logic sup;
    } link_ctl_t;

    localparam logic [1:0] KIND_KEPT    = 2'd0;
    localparam logic [1:0] KIND_PAD     = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [1:0] REG_MAX_OUTPUT = 2'd0;
    localparam logic [1:0] REG_IOU_THR    = 2'd1;

    localparam logic [5:0]  MAX_OUTPUT_RST = 6'd32;
    localparam logic [15:0] IOU_THR_RST    = 16'd32768;

endpackage

FILE: rtl/greedy_box_nms_top.sv
// Channel  Direction  Payload               Handshake
// s_       in         gbn_pkg::in_item_t    s_valid / s_ready
// m_       out        gbn_pkg::out_item_t   m_valid / m_ready
// cfg_     in         cfg_index, cfg_data   cfg_valid / cfg_ready
// An item that is tested passes through every cell of the chain, then the decide step.
// An item arriving with the keep limit reached goes straight to the tail step; a closing item
// then emits padding results up to the keep limit, followed by the summary.
// Reset is synchronous; no clearing pass. A stalled m_ready holds the sequencer.
// Top level of greedy box suppression; depends on gbn_pkg and gbn_cell.
module greedy_box_nms_top #(
    parameter int MAX_KEPT   = 32,
    parameter int COORD_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gbn_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output gbn_pkg::out_item_t m_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    localparam int CW = COORD_BITS;
    localparam int D  = CW + 1;
    localparam int AW = 2 * CW + 2;
    localparam int KW = $clog2(MAX_KEPT + 1);
    localparam int IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam logic [5:0] MAXK6 = 6'(MAX_KEPT);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_TAIL   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [5:0]  max_out_reg;
    logic [15:0] thr_reg;

    logic [KW-1:0] kept_reg, kept_next;
    logic [KW-1:0] pad_reg, pad_next;
    logic [15:0]   cnt_reg, cnt_next;
    logic [15:0]   lastk_reg, lastk_next;
    logic          last_reg, sup_reg;

    gbn_pkg::link_ctl_t     head_ctl_reg;
    logic [4*CW-1:0]        head_box_reg;
    logic signed [AW-1:0]   head_area_reg;

    logic                   m_valid_reg, m_valid_next;
    gbn_pkg::out_item_t     m_item_reg, m_item_next;

    logic [5:0] limit;
    logic       out_free, wr_go;
    logic [CW-1:0] ix0, iy0, ix1, iy1;
    logic signed [D-1:0] dx, dy;

    gbn_pkg::link_ctl_t   ctl_w  [MAX_KEPT+1];
    logic [4*CW-1:0]      box_w  [MAX_KEPT+1];
    logic signed [AW-1:0] area_w [MAX_KEPT+1];

    always_comb begin
        limit = max_out_reg;
        if (limit == 6'd0) limit = 6'd1;
        if (limit > MAXK6) limit = MAXK6;
        out_free = !m_valid_reg || m_ready;
        ix0 = CW'(s_item.left);
        iy0 = CW'(s_item.top);
        ix1 = CW'(s_item.right);
        iy1 = CW'(s_item.bottom);
        dx = $signed({1'b0, ix1}) - $signed({1'b0, ix0});
        dy = $signed({1'b0, iy1}) - $signed({1'b0, iy0});
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    assign ctl_w[0]  = head_ctl_reg;
    assign box_w[0]  = head_box_reg;
    assign area_w[0] = head_area_reg;

    for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
        gbn_cell #(.CW(CW)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_ctl   (ctl_w[i]),
            .in_box   (box_w[i]),
            .in_area  (area_w[i]),
            .active   (kept_reg > KW'(i)),
            .thr      (thr_reg),
            .wr_en    (wr_go && (kept_reg[IW-1:0] == IW'(i))),
            .wr_box   (head_box_reg),
            .wr_area  (head_area_reg),
            .out_ctl  (ctl_w[i+1]),
            .out_box  (box_w[i+1]),
            .out_area (area_w[i+1])
        );
    end

    always_comb begin
        state_next   = state_reg;
        kept_next    = kept_reg;
        pad_next     = kept_reg;
        cnt_next     = cnt_reg;
        lastk_next   = lastk_reg;
        wr_go        = 1'b0;
        m_valid_next = m_valid_reg & ~m_ready;
        m_item_next  = m_item_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = ({2'b00, kept_reg} < {2'b00, limit}) ? S_SCAN : S_TAIL;
                end
            end
            S_SCAN: begin
                if (ctl_w[MAX_KEPT].valid) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (sup_reg) begin
                    state_next = S_TAIL;
                end else if (out_free) begin
                    wr_go        = 1'b1;
                    kept_next    = kept_reg + KW'(1);
                    pad_next     = kept_reg + KW'(1);
                    lastk_next   = cnt_reg;
                    m_valid_next = 1'b1;
                    m_item_next  = '{cnt_reg, gbn_pkg::KIND_KEPT, 6'd0, 1'b0};
                    state_next   = S_TAIL;
                end
            end
            S_TAIL: begin
                pad_next = pad_reg;
                if (!last_reg) begin
                    if (cnt_reg != 16'hFFFF) cnt_next = cnt_reg + 16'd1;
                    state_next = S_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    if ({2'b00, pad_reg} < {2'b00, limit}) begin
                        m_item_next = '{lastk_reg, gbn_pkg::KIND_PAD, 6'd0, 1'b0};
                        pad_next    = pad_reg + KW'(1);
                    end else begin
                        m_item_next = '{16'd0, gbn_pkg::KIND_SUMMARY, 6'(kept_reg), 1'b1};
                        kept_next   = '0;
                        pad_next    = '0;
                        cnt_next    = '0;
                        lastk_next  = '0;
                        state_next  = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
        if (s_valid && s_ready) begin
            head_box_reg  <= {ix0, iy0, ix1, iy1};
            head_area_reg <= AW'(dx) * AW'(dy);
            last_reg      <= s_item.last_box;
        end
        if (state_reg == S_SCAN) sup_reg <= ctl_w[MAX_KEPT].sup;
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            kept_reg     <= '0;
            pad_reg      <= '0;
            cnt_reg      <= '0;
            lastk_reg    <= '0;
            head_ctl_reg <= '0;
            m_valid_reg  <= 1'b0;
            max_out_reg  <= gbn_pkg::MAX_OUTPUT_RST;
            thr_reg      <= gbn_pkg::IOU_THR_RST;
        end else begin
            state_reg          <= state_next;
            kept_reg           <= kept_next;
            pad_reg            <= pad_next;
            cnt_reg            <= cnt_next;
            lastk_reg          <= lastk_next;
            m_valid_reg        <= m_valid_next;
            head_ctl_reg.valid <= s_valid && s_ready &&
                                  ({2'b00, kept_reg} < {2'b00, limit});
            head_ctl_reg.sup   <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == gbn_pkg::REG_MAX_OUTPUT) max_out_reg <= cfg_data[5:0];
                if (cfg_index == gbn_pkg::REG_IOU_THR)    thr_reg     <= cfg_data;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_ready_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("input taken twice");
    a_kept_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {2'b00, kept_reg} <= {2'b00, MAXK6}) else $error("kept count overflow");
    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.result_kind == gbn_pkg::KIND_SUMMARY |-> m_item.last_result)
        else $error("summary without last flag");
    a_summary_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_next && !m_valid_reg && m_item_next.last_result |=> kept_reg == '0)
        else $error("set state not cleared");

endmodule

FILE: rtl/gbn_cell.sv
// One cell of the suppression chain: holds one kept box and its area, and
// tests the box passing through against it over two stages.
// Depends on gbn_pkg.
module gbn_cell #(
    parameter int CW = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  gbn_pkg::link_ctl_t       in_ctl,
    input  logic [4*CW-1:0]          in_box,
    input  logic signed [2*CW+1:0]   in_area,
    input  logic                     active,
    input  logic [15:0]              thr,
    input  logic                     wr_en,
    input  logic [4*CW-1:0]          wr_box,
    input  logic signed [2*CW+1:0]   wr_area,
    output gbn_pkg::link_ctl_t       out_ctl,
    output logic [4*CW-1:0]          out_box,
    output logic signed [2*CW+1:0]   out_area
);
    localparam int D  = CW + 1;
    localparam int NW = 2 * CW;
    localparam int UW = 2 * CW + 4;
    localparam int PW = UW + 16;

    logic [4*CW-1:0]        kbox_reg;
    logic signed [2*CW+1:0] karea_reg;

    gbn_pkg::link_ctl_t     s1_ctl_reg;
    logic [4*CW-1:0]        s1_box_reg;
    logic signed [2*CW+1:0] s1_area_reg;
    logic [2*CW-1:0]        s1_inter_reg;
    logic signed [UW-1:0]   s1_uni_reg;
    logic                   s1_act_reg;

    gbn_pkg::link_ctl_t     out_ctl_reg;
    logic [4*CW-1:0]        out_box_reg;
    logic signed [2*CW+1:0] out_area_reg;

    logic [CW-1:0]        nx0, ny0, nx1, ny1, kx0, ky0, kx1, ky1;
    logic [CW-1:0]        l, r, t, m, w, h;
    logic signed [D-1:0]  wd, hd;
    logic [2*CW-1:0]      inter;
    logic signed [UW-1:0] uni;
    logic [PW-1:0]        lhs, rhs;
    logic                 hit;

    always_comb begin
        nx0 = in_box[4*CW-1:3*CW];
        ny0 = in_box[3*CW-1:2*CW];
        nx1 = in_box[2*CW-1:CW];
        ny1 = in_box[CW-1:0];
        kx0 = kbox_reg[4*CW-1:3*CW];
        ky0 = kbox_reg[3*CW-1:2*CW];
        kx1 = kbox_reg[2*CW-1:CW];
        ky1 = kbox_reg[CW-1:0];
        l = (nx0 > kx0) ? nx0 : kx0;
        r = (nx1 < kx1) ? nx1 : kx1;
        t = (ny0 > ky0) ? ny0 : ky0;
        m = (ny1 < ky1) ? ny1 : ky1;
        wd = $signed({1'b0, r}) - $signed({1'b0, l});
        hd = $signed({1'b0, m}) - $signed({1'b0, t});
        w = (wd > 0) ? wd[CW-1:0] : '0;
        h = (hd > 0) ? hd[CW-1:0] : '0;
        inter = NW'(w) * NW'(h);
        uni = UW'(in_area) + UW'(karea_reg) - $signed(UW'({2'b00, inter}));
    end

    always_comb begin
        lhs = PW'({s1_inter_reg, 16'h0000});
        rhs = PW'(s1_uni_reg[UW-1:0]) * PW'(thr);
        if (s1_uni_reg <= 0) begin
            hit = (s1_inter_reg != '0) || ((s1_uni_reg < 0) && (thr != 16'h0000));
        end else begin
            hit = lhs > rhs;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            kbox_reg  <= wr_box;
            karea_reg <= wr_area;
        end
        s1_box_reg   <= in_box;
        s1_area_reg  <= in_area;
        s1_inter_reg <= inter;
        s1_uni_reg   <= uni;
        s1_act_reg   <= active;
        out_box_reg  <= s1_box_reg;
        out_area_reg <= s1_area_reg;
        if (!aresetn) begin
            s1_ctl_reg  <= '0;
            out_ctl_reg <= '0;
        end else begin
            s1_ctl_reg        <= in_ctl;
            out_ctl_reg.valid <= s1_ctl_reg.valid;
            out_ctl_reg.sup   <= s1_ctl_reg.sup | (s1_act_reg & hit);
        end
    end

    assign out_ctl  = out_ctl_reg;
    assign out_box  = out_box_reg;
    assign out_area = out_area_reg;

endmodule

FILE: tb/gbn_nms_checker.sv
`timescale 1ns / 100ps
// Checker for greedy_box_nms_top: watches the input, config and result channels,
// predicts kept, padding and summary results, and counts mismatches.
// Depends on gbn_pkg.
module gbn_nms_checker #(
    parameter int MAX_KEPT = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  gbn_pkg::in_item_t  s_item,
    input  logic               m_valid,
    input  logic               m_ready,
    input  gbn_pkg::out_item_t m_item,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 results_seen
);
    typedef struct {
        longint x0, y0, x1, y1;
    } box_t;

    box_t       kept_q[MAX_KEPT];
    int         kept_n;
    int         box_ctr;
    int         last_kept;
    logic [5:0] lim_reg;
    logic [15:0] thr_reg;
    gbn_pkg::out_item_t expected_q[$];

    assign pending = expected_q.size();

    function automatic bit is_overlap(box_t a, box_t b, logic [15:0] thr);
        longint l, r, t, m, w, h, inter, uni;
        logic [127:0] lhs, rhs;
        l = a.x0 > b.x0 ? a.x0 : b.x0;
        r = a.x1 < b.x1 ? a.x1 : b.x1;
        t = a.y0 > b.y0 ? a.y0 : b.y0;
        m = a.y1 < b.y1 ? a.y1 : b.y1;
        w = r - l > 0 ? r - l : 0;
        h = m - t > 0 ? m - t : 0;
        inter = w * h;
        uni = (a.x1 - a.x0) * (a.y1 - a.y0) + (b.x1 - b.x0) * (b.y1 - b.y0) - inter;
        if (uni <= 0) begin
            if (inter > 0) return 1;
            return uni < 0 && thr > 0;
        end
        lhs = 128'(inter) * 128'd65536;
        rhs = 128'(uni) * 128'(thr);
        return lhs > rhs;
    endfunction

    task automatic push_result(int idx, logic [1:0] kind, int cnt, bit last);
        gbn_pkg::out_item_t r;
        r.box_index   = idx[15:0];
        r.result_kind = kind;
        r.kept_count  = cnt[5:0];
        r.last_result = last;
        expected_q.push_back(r);
    endtask

    task automatic predict_box(gbn_pkg::in_item_t it);
        box_t nb;
        int   limit;
        bit   sup;
        nb.x0 = it.left;
        nb.y0 = it.top;
        nb.x1 = it.right;
        nb.y1 = it.bottom;
        limit = lim_reg;
        if (limit < 1) limit = 1;
        if (limit > MAX_KEPT) limit = MAX_KEPT;
        if (kept_n < limit) begin
            sup = 0;
            for (int i = 0; i < kept_n; i++)
                if (is_overlap(nb, kept_q[i], thr_reg)) sup = 1;
            if (!sup) begin
                kept_q[kept_n] = nb;
                kept_n++;
                last_kept = box_ctr;
                push_result(box_ctr, gbn_pkg::KIND_KEPT, 0, 0);
            end
        end
        if (it.last_box) begin
            for (int i = kept_n; i < limit; i++)
                push_result(last_kept, gbn_pkg::KIND_PAD, 0, 0);
            push_result(0, gbn_pkg::KIND_SUMMARY, kept_n, 1);
            kept_n = 0;
            box_ctr = 0;
            last_kept = 0;
        end else if (box_ctr < 65535) begin
            box_ctr++;
        end
    endtask

    always @(posedge aclk) begin
        gbn_pkg::out_item_t e;
        if (!aresetn) begin
            kept_n = 0;
            box_ctr = 0;
            last_kept = 0;
            lim_reg = gbn_pkg::MAX_OUTPUT_RST;
            thr_reg = gbn_pkg::IOU_THR_RST;
            fail_count <= 0;
            results_seen <= 0;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    $error("unexpected result item %p", m_item);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e != m_item) begin
                        fail_count <= fail_count + 1;
                        if (e.box_index != m_item.box_index)
                            $error("box_index exp %0d got %0d", e.box_index, m_item.box_index);
                        if (e.result_kind != m_item.result_kind)
                            $error("result_kind exp %0d got %0d", e.result_kind,
                                   m_item.result_kind);
                        if (e.kept_count != m_item.kept_count)
                            $error("kept_count exp %0d got %0d", e.kept_count,
                                   m_item.kept_count);
                        if (e.last_result != m_item.last_result)
                            $error("last_result exp %0d got %0d", e.last_result,
                                   m_item.last_result);
                    end
                end
            end
            if (s_valid && s_ready) predict_box(s_item);
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == gbn_pkg::REG_MAX_OUTPUT) lim_reg = cfg_data[5:0];
                else if (cfg_index == gbn_pkg::REG_IOU_THR) thr_reg = cfg_data;
            end
        end
    end
endmodule

FILE: tb/greedy_box_nms_top_tb.sv
`timescale 1ns / 100ps
// Top of the greedy box suppression testbench: clock, reset, box and config
// stimulus, result back-pressure and verdict. Depends on gbn_pkg, greedy_box_nms_top and gbn_nms_checker.
module greedy_box_nms_top_tb;
    localparam int TAIL_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 2_000_000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    gbn_pkg::in_item_t  s_item;
    logic       m_valid;
    logic       m_ready;
    gbn_pkg::out_item_t m_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;
    int         fail_count;
    int         pending;
    int         results_seen;
    longint     cycle_ctr = 0;
    int         boxes_sent;
    int         sets_sent;
    bit         hold_off;

    greedy_box_nms_top u_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_item, .m_valid, .m_ready, .m_item,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    gbn_nms_checker u_chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_item, .m_valid, .m_ready, .m_item,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending,
        .results_seen
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_ctr <= cycle_ctr + 1;
        if (cycle_ctr > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_ctr);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int gap;
        bit held;
        held = 0;
        m_ready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off && !held) begin
                held = 1;
                m_ready <= 0;
                repeat (400) @(posedge aclk);
            end
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk iff m_valid && m_ready);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk iff cfg_ready);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk iff pending == 0);
        repeat (80) @(posedge aclk);
    endtask

    task automatic send_box(logic [15:0] l, logic [15:0] t, logic [15:0] r,
                            logic [15:0] b, bit last, bit pace = 1);
        int gap;
        gap = pace ? $urandom_range(0, 5) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_item  <= '{left: l, top: t, right: r, bottom: b, last_box: last};
        @(posedge aclk iff s_ready);
        boxes_sent++;
        if (last) sets_sent++;
    endtask

    task automatic random_box(bit last);
        logic [15:0] x, y, w, h;
        case ($urandom_range(0, 9))
            0: send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), last);
            1: send_box(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                        16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)), last);
            default: begin
                x = 16'($urandom_range(0, 300));
                y = 16'($urandom_range(0, 300));
                w = 16'($urandom_range(1, 120));
                h = 16'($urandom_range(1, 120));
                if ($urandom_range(0, 15) == 0) begin
                    x = x + 16'hFE00;
                    y = y + 16'hFE00;
                end
                send_box(x, y, x + w, y + h, last);
            end
        endcase
    endtask

    task automatic random_set(int n);
        for (int i = 0; i < n; i++) random_box(i == n - 1);
    endtask

    initial begin
        int n;
        aresetn = 0;
        s_valid = 0;
        s_item = '0;
        cfg_valid = 0;
        cfg_index = gbn_pkg::REG_MAX_OUTPUT;
        cfg_data = '0;
        boxes_sent = 0;
        sets_sent = 0;
        hold_off = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_box(0, 0, 100, 100, 0);
        send_box(10, 10, 110, 110, 0);
        send_box(50, 0, 150, 100, 0);
        send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        send_box(16'hFFFF, 16'hFFFF, 0, 0, 0);
        send_box(0, 0, 16'hFFFF, 16'hFFFF, 0);
        send_box(300, 300, 200, 400, 1);
        send_box(5, 5, 5, 5, 1);
        drain();
        write_reg(gbn_pkg::REG_MAX_OUTPUT, 16'd0);
        write_reg(gbn_pkg::REG_IOU_THR, 16'd0);
        write_reg(2'd2, 16'hFFFF);
        write_reg(2'd3, 16'h0001);
        send_box(0, 0, 10, 10, 0);
        send_box(500, 500, 510, 510, 1);
        send_box(20, 20, 10, 10, 1);
        drain();
        write_reg(gbn_pkg::REG_MAX_OUTPUT, 16'hFFFF);
        write_reg(gbn_pkg::REG_IOU_THR, 16'hFFFF);
        send_box(0, 0, 10, 10, 0);
        send_box(0, 0, 10, 10, 0);
        send_box(1, 1, 10, 10, 0);
        send_box(0, 0, 16'hFFFF, 16'hFFFF, 1);
        drain();
        write_reg(gbn_pkg::REG_MAX_OUTPUT, 16'd3);
        write_reg(gbn_pkg::REG_IOU_THR, 16'd1);
        send_box(0, 0, 100, 100, 0);
        drain();
        write_reg(gbn_pkg::REG_MAX_OUTPUT, 16'd3);
        send_box(200, 200, 300, 300, 0);
        drain();
        write_reg(gbn_pkg::REG_MAX_OUTPUT, 16'd1);
        send_box(400, 400, 500, 500, 1);
        drain();

        write_reg(gbn_pkg::REG_MAX_OUTPUT, 16'd8);
        write_reg(gbn_pkg::REG_IOU_THR, 16'd32768);
        hold_off = 1;
        for (int i = 0; i < 20; i++) random_box(i == 19);
        drain();

        while (boxes_sent < 355) begin
            if ($urandom_range(0, 4) == 0) begin
                drain();
                write_reg(gbn_pkg::REG_MAX_OUTPUT,
                          $urandom_range(0, 6) == 0 ? 16'($urandom_range(32, 63))
                                                    : 16'($urandom_range(1, 12)));
                write_reg(gbn_pkg::REG_IOU_THR,
                          $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                    : 16'($urandom_range(8000, 50000)));
            end
            n = $urandom_range(1, 12);
            if ($urandom_range(0, 10) == 0) n = $urandom_range(30, 45);
            random_set(n);
        end

        drain();
        write_reg(gbn_pkg::REG_MAX_OUTPUT, 16'd2);
        for (int i = 0; i < 10; i++)
            send_box(16'd1000, 16'd1000, 16'd1000, 16'd1000, i == 9, 0);
        drain();
        write_reg(gbn_pkg::REG_MAX_OUTPUT, 16'd32);
        write_reg(gbn_pkg::REG_IOU_THR, 16'd0);
        for (int i = 0; i < 40; i++)
            send_box(16'(i * 1000), 16'd0, 16'(i * 1000 + 10), 16'd10, i == 39);

        s_valid <= 0;
        @(posedge aclk iff pending == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("covered %0d boxes in %0d sets, %0d results checked", boxes_sent, sets_sent,
                 results_seen);
        $display("includes limit and threshold extremes, inverted boxes, sets past the limit");
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

FILE: filelist.f
rtl/gbn_pkg.sv
rtl/gbn_cell.sv
rtl/greedy_box_nms_top.sv
tb/gbn_nms_checker.sv
tb/greedy_box_nms_top_tb.sv
